[rtl/k2q_pkg.sv]
// ----------------------------------------------------------------------------
// k2q_pkg
// Shared types, codes and helpers for the k2-tree adjacency query block.
// ----------------------------------------------------------------------------
package k2q_pkg;

  localparam int TREE_DEPTH         = 65536;
  localparam int LEAF_DEPTH         = 131072;
  localparam int SUPERBLOCK_ENTRIES = 65536;
  localparam int MAX_HEIGHT         = 24;

  localparam int INT_AW  = $clog2(TREE_DEPTH);
  localparam int LEAF_AW = $clog2(LEAF_DEPTH);
  localparam int SB_AW   = $clog2(SUPERBLOCK_ENTRIES);

  // command codes
  localparam logic [2:0] CMD_QUERY    = 3'd0;
  localparam logic [2:0] CMD_INTERNAL = 3'd1;
  localparam logic [2:0] CMD_LEAF     = 3'd2;
  localparam logic [2:0] CMD_SUPER    = 3'd3;
  localparam logic [2:0] CMD_SUB      = 3'd4;

  // register indexes
  localparam logic [2:0] REG_BRANCHING = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_NODES     = 3'd2;
  localparam logic [2:0] REG_PADDED    = 3'd3;
  localparam logic [2:0] REG_INT_BITS  = 3'd4;
  localparam logic [2:0] REG_SB_WORDS  = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [23:0] row_node;
    logic [23:0] col_node;
    logic [16:0] load_address;
    logic [31:0] load_data;
  } query_item_t;

  typedef struct packed {
    logic is_edge;
    logic out_of_range;
  } query_result_t;

  // population count in five folding steps
  function automatic logic [5:0] pop32(input logic [31:0] x);
    logic [31:0] a;
    a = (x & 32'h5555_5555) + ((x >> 1) & 32'h5555_5555);
    a = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    a = (a & 32'h0F0F_0F0F) + ((a >> 4) & 32'h0F0F_0F0F);
    a = (a & 32'h00FF_00FF) + ((a >> 8) & 32'h00FF_00FF);
    a = (a & 32'h0000_FFFF) + ((a >> 16) & 32'h0000_FFFF);
    return a[5:0];
  endfunction

endpackage

[rtl/k2q_div.sv]
// ----------------------------------------------------------------------------
// k2q_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module k2q_div import k2q_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] trial;

  // trial subtract of the shifted partial remainder
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial[32]) begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) busy <= 1'b0;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  // a division runs exactly 32 steps
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt <= 6'd31)
    else $error("divider step count overran");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  // the last step ends the division unless a new start comes with it
  assert property (@(posedge clk) disable iff (rst) busy && cnt == 6'd31 && !start |=> !busy)
    else $error("divider did not finish");

endmodule

[rtl/k2tree_adjacency_query.sv]
// ----------------------------------------------------------------------------
// k2tree_adjacency_query
// Edge lookup in a k2-tree adjacency bitmap with a two-level rank directory.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data  (query_item_t)
//   out     | output    | out_valid / out_ready | out_data (query_result_t)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Load items are written to memory as they are accepted. Each internal
// level runs four divisions on the shared divider (block size, row,
// column, superblock index) plus four steps. A query of height h walks
// h-1 internal levels and then a leaf lookup; early exits end sooner.
// Reset is synchronous; memories keep their contents.
// in_ready is high only while the sequencer idles; a stalled result holds
// the sequencer in its finish state. cfg_ready is always high.
// ----------------------------------------------------------------------------
module k2tree_adjacency_query import k2q_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  query_item_t   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output query_result_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_BS_GO, ST_BS_WAIT, ST_DU_GO, ST_DU_WAIT, ST_DV_GO, ST_DV_WAIT,
    ST_POS, ST_SB_GO, ST_SB_WAIT, ST_RD, ST_TEST, ST_MUL, ST_LEAF_POS,
    ST_LEAF_RD, ST_LEAF_TEST, ST_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [2:0]  k;
  logic [4:0]  height;
  logic [23:0] nodes;
  logic [24:0] padded;
  logic [21:0] int_bits;
  logic [10:0] sb_words;

  // memories
  logic [31:0] internal_bitmap [TREE_DEPTH];
  logic [31:0] leaf_bitmap [LEAF_DEPTH];
  logic [21:0] superblock_counts [SUPERBLOCK_ENTRIES];
  logic [15:0] subblock_counts [TREE_DEPTH];

  // walk state
  logic [24:0] cur;
  logic [24:0] bs;
  logic [23:0] u;
  logic [23:0] v;
  logic [23:0] qu;
  logic [23:0] qv;
  logic [23:0] ur;
  logic [23:0] vr;
  logic [31:0] offset;
  logic [31:0] pos;
  logic [31:0] rank;
  logic [31:0] sb;
  logic [4:0]  lvl_left;
  logic        res_edge;
  logic        res_oor;

  // registered memory reads
  logic [31:0] int_rd;
  logic [15:0] sub_rd;
  logic [21:0] sup_rd;
  logic [31:0] leaf_rd;
  logic        w_ok;
  logic        sb_ok;
  logic        leaf_ok;

  // shared divider
  logic        div_start;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        div_busy;
  logic [31:0] div_q;
  logic [31:0] div_r;

  k2q_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (div_q),
    .remainder(div_r)
  );

  logic        in_acc;
  logic [5:0]  k2;
  logic [26:0] t_pos;
  logic [31:0] word;
  logic [31:0] mask;
  logic [10:0] sb_eff;
  logic        out_free;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign k2        = 6'({3'b0, k} * {3'b0, k});
  assign t_pos     = 27'(27'(qu) * 27'(k)) + 27'(qv);
  assign word      = w_ok ? int_rd : 32'd0;
  assign mask      = (32'd1 << pos[4:0]) - 32'd1;
  assign sb_eff    = (sb_words == 11'd0) ? 11'd1 : sb_words;
  assign out_free  = !out_valid || out_ready;

  // divider operands and start
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = 32'd1;
    unique case (state)
      ST_BS_GO: begin
        div_start = 1'b1;
        div_a     = 32'(cur);
        div_b     = 32'(k);
      end
      ST_DU_GO: begin
        div_start = 1'b1;
        div_a     = 32'(u);
        div_b     = 32'(bs);
      end
      ST_DV_GO: begin
        div_start = 1'b1;
        div_a     = 32'(v);
        div_b     = 32'(bs);
      end
      ST_SB_GO: begin
        div_start = 1'b1;
        div_a     = {5'd0, pos[31:5]};
        div_b     = 32'(sb_eff);
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= 3'd2;
      height   <= '0;
      nodes    <= '0;
      padded   <= 25'd1;
      int_bits <= '0;
      sb_words <= 11'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BRANCHING: k        <= cfg_data[2:0];
        REG_HEIGHT:    height   <= cfg_data[4:0];
        REG_NODES:     nodes    <= cfg_data[23:0];
        REG_PADDED:    padded   <= cfg_data[24:0];
        REG_INT_BITS:  int_bits <= cfg_data[21:0];
        REG_SB_WORDS:  sb_words <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // memory writes from load items
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_data.cmd == CMD_INTERNAL && in_data.load_address[16] == 1'b0)
        internal_bitmap[in_data.load_address[INT_AW-1:0]] <= in_data.load_data;
      if (in_data.cmd == CMD_LEAF)
        leaf_bitmap[in_data.load_address[LEAF_AW-1:0]] <= in_data.load_data;
      if (in_data.cmd == CMD_SUPER && in_data.load_address[16] == 1'b0)
        superblock_counts[in_data.load_address[SB_AW-1:0]] <= in_data.load_data[21:0];
      if (in_data.cmd == CMD_SUB && in_data.load_address[16] == 1'b0)
        subblock_counts[in_data.load_address[INT_AW-1:0]] <= in_data.load_data[15:0];
    end
  end

  // memory reads
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      int_rd <= internal_bitmap[pos[INT_AW+4:5]];
      sub_rd <= subblock_counts[pos[INT_AW+4:5]];
      sup_rd <= superblock_counts[sb[SB_AW-1:0]];
      w_ok   <= (pos[31:INT_AW+5] == '0);
      sb_ok  <= (sb[31:SB_AW] == '0);
    end
    if (state == ST_LEAF_RD) begin
      leaf_rd <= leaf_bitmap[pos[LEAF_AW+4:5]];
      leaf_ok <= (pos[31:LEAF_AW+5] == '0);
    end
  end

  // query sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result register: set on issue, cleared once taken
      if (state == ST_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc && in_data.cmd == CMD_QUERY) begin
            res_edge <= 1'b0;
            res_oor  <= 1'b0;
            cur      <= padded;
            u        <= in_data.row_node;
            v        <= in_data.col_node;
            offset   <= '0;
            lvl_left <= height - 5'd1;
            if (in_data.row_node >= nodes || in_data.col_node >= nodes) begin
              res_oor <= 1'b1;
              state   <= ST_FIN;
            end else if (height == 5'd0 || height > 5'(MAX_HEIGHT) || k < 3'd2) begin
              state <= ST_FIN;
            end else begin
              state <= ST_BS_GO;
            end
          end
        end
        ST_BS_GO: state <= ST_BS_WAIT;
        ST_BS_WAIT: begin
          if (!div_busy) begin
            bs <= div_q[24:0];
            if (div_q == '0) state <= ST_FIN;
            else             state <= ST_DU_GO;
          end
        end
        ST_DU_GO: state <= ST_DU_WAIT;
        ST_DU_WAIT: begin
          if (!div_busy) begin
            qu    <= div_q[23:0];
            ur    <= div_r[23:0];
            state <= ST_DV_GO;
          end
        end
        ST_DV_GO: state <= ST_DV_WAIT;
        ST_DV_WAIT: begin
          if (!div_busy) begin
            qv    <= div_q[23:0];
            vr    <= div_r[23:0];
            state <= ST_POS;
          end
        end
        ST_POS: begin
          if (lvl_left == 5'd0) begin
            pos   <= 32'(t_pos);
            state <= ST_LEAF_RD;
          end else begin
            pos   <= offset + 32'(t_pos);
            state <= ST_SB_GO;
          end
        end
        ST_SB_GO: state <= ST_SB_WAIT;
        ST_SB_WAIT: begin
          if (!div_busy) begin
            sb    <= div_q;
            state <= ST_RD;
          end
        end
        ST_RD: state <= ST_TEST;
        ST_TEST: begin
          if (!word[pos[4:0]]) begin
            state <= ST_FIN;
          end else begin
            rank  <= (sb_ok ? 32'(sup_rd) : 32'd0) + 32'(sub_rd)
                     + 32'(pop32(word & mask)) + 32'd1;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          offset   <= 32'(32'(k2) * rank);
          u        <= ur;
          v        <= vr;
          cur      <= bs;
          lvl_left <= lvl_left - 5'd1;
          if (lvl_left == 5'd1) state <= ST_LEAF_POS;
          else                  state <= ST_BS_GO;
        end
        ST_LEAF_POS: begin
          pos   <= offset - 32'(int_bits) + 32'(27'(27'(u) * 27'(k))) + 32'(v);
          state <= ST_LEAF_RD;
        end
        ST_LEAF_RD: state <= ST_LEAF_TEST;
        ST_LEAF_TEST: begin
          res_edge <= leaf_ok & leaf_rd[pos[4:0]];
          state    <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_data.is_edge      <= res_edge;
            out_data.out_of_range <= res_oor;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider is never restarted mid-division
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");
  // a level step always has a level left to walk
  assert property (@(posedge clk) disable iff (rst) state == ST_MUL |-> lvl_left != 5'd0)
    else $error("level count underflow");
  // out of range and edge are never reported together
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.is_edge && out_data.out_of_range))
    else $error("conflicting result flags");

endmodule
